// ===== sv/assert_macros.svh =====
// Assertion macros shared by the base64 decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on clk, disabled while arst_n is low.
`define B64D_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication check on clk.
`define B64D_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
// Package: shared types, constants and the alphabet lookup of the base64 decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One decode job handed from front to back: up to three bytes of a quad.
	typedef struct packed {
		logic [23:0] word;  // decoded bytes, first byte in the high bits
		logic [1:0]  cnt;   // results to emit, 1..3
		logic        bad;   // error result
		logic        done;  // message ends with this job
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// 0..63 for alphabet characters, 64 (bit 6 set) otherwise.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = 7'd64;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder: front, job queue and back.
//
// channel | dir | tdata                      | tuser          | tlast
// --------+-----+----------------------------+----------------+-------------
// s_*     | in  | [7:0] char_in              | -              | message_end
// m_*     | out | [7:0] byte_out, [8] group_last, rest 0 | [0] bad_input | message_done
//
// One character is taken per cycle while the job queue has room; the front
// updates the quad state in the cycle it takes the request.
// The back emits one result per cycle while m_tready allows, so a quad's one to three
// bytes leave one after another; the queue (QUEUE_DEPTH jobs) absorbs the difference.
// Once the character that completes a quad is accepted, its first result passes the
// queue write and then the output register load before it can be taken.
// arst_n clears quad state, queue pointers and the output valid flag.
// m_tready low stalls the back only; s_tready drops once the queue fills.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	input  wire logic        s_tlast,   // message_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] byte_out, [8] group_last, [15:9] zero
	output logic             m_tlast,   // message_done
	output logic [0:0]       m_tuser    // [0] bad_input
);

	b64d_pkg::job_t          push_job;
	b64d_pkg::job_t          head;
	b64d_pkg::queue_status_t q_status;
	logic                    push;
	logic                    pop;
	logic [7:0]              out_byte;
	logic                    out_group_last;
	logic                    out_bad;

	// Front: classify each character and build jobs at quad end / early end.
	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_char  (s_tdata),
		.in_end   (s_tlast),
		.q_status (q_status),
		.in_ready (s_tready),
		.push     (push),
		.job      (push_job)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// Back: one result per cycle out of the head job while the output is not stalled.
	b64d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_status       (q_status),
		.pop            (pop),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_byte       (out_byte),
		.out_group_last (out_group_last),
		.out_done       (m_tlast),
		.out_bad        (out_bad)
	);

	assign m_tdata = {7'd0, out_group_last, out_byte};
	assign m_tuser = out_bad;

	// The front must never push into a full queue; that job would be lost.
	`B64D_ASSERT(a_no_push_full, !(push && q_status.full), "job pushed into full queue")
	// Error results carry a zero byte and close their group.
	`B64D_ASSERT_IMPLY(a_bad_shape, m_tvalid && out_bad, m_tdata[8:0] == 9'h100, "bad error result")
	// End of message always falls on a group boundary.
	`B64D_ASSERT_IMPLY(a_done_last, m_tvalid && m_tlast, out_group_last, "message_done without group_last")

endmodule
`default_nettype wire

// ===== sv/b64d_front.sv =====
// Front end: accepts characters, tracks the quad and pushes decode jobs.
`timescale 1ns / 1ps
`default_nettype none
module b64d_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic [7:0]              in_char,
	input  wire logic                    in_end,
	input  wire b64d_pkg::queue_status_t q_status,
	output logic                         in_ready,
	output logic                         push,
	output b64d_pkg::job_t               job
);

	logic [1:0]  phase_q;
	logic [17:0] acc_q;
	logic [1:0]  pad_q;
	logic        invalid_q;

	logic        accept;
	logic        is_pad;
	logic [6:0]  sx;
	logic [5:0]  v;
	logic        inv_n;
	logic [1:0]  pad_n;
	logic [17:0] acc_n;
	logic        clear;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_pad = (in_char == b64d_pkg::PAD_CHAR);
		sx     = b64d_pkg::sextet_of(in_char);
		v      = (is_pad || sx[6]) ? 6'd0 : sx[5:0];
		inv_n  = invalid_q
			| (is_pad && phase_q < 2'd2)
			| (!is_pad && (sx[6] || pad_q != 2'd0));
		pad_n  = (is_pad && phase_q >= 2'd2 && pad_q < 2'd2) ? pad_q + 2'd1 : pad_q;
		acc_n  = {acc_q[11:0], v};

		push     = 1'b0;
		clear    = 1'b0;
		job.word = 24'd0;
		job.cnt  = 2'd1;
		job.bad  = 1'b1;
		job.done = in_end;
		if (phase_q < 2'd3) begin
			// early end of message: one error result
			if (in_end) begin
				push  = accept;
				clear = 1'b1;
			end
		end else begin
			push  = accept;
			clear = 1'b1;
			if (!inv_n) begin
				job.word = {acc_q, v};
				job.cnt  = 2'd3 - pad_n;
				job.bad  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			acc_q     <= 18'd0;
			pad_q     <= 2'd0;
			invalid_q <= 1'b0;
		end else if (accept) begin
			if (clear) begin
				phase_q   <= 2'd0;
				acc_q     <= 18'd0;
				pad_q     <= 2'd0;
				invalid_q <= 1'b0;
			end else begin
				phase_q   <= phase_q + 2'd1;
				acc_q     <= acc_n;
				pad_q     <= pad_n;
				invalid_q <= inv_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/b64d_queue.sv =====
// Job queue between front and back: small register FIFO.
`timescale 1ns / 1ps
`default_nettype none
module b64d_queue #(
	parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b64d_pkg::job_t        push_job,
	input  wire logic                  pop,
	output b64d_pkg::job_t             head,
	output b64d_pkg::queue_status_t    status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/b64d_back.sv =====
// Back end: walks the head job byte by byte into the output register.
`timescale 1ns / 1ps
`default_nettype none
module b64d_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire b64d_pkg::job_t          head,
	input  wire b64d_pkg::queue_status_t q_status,
	output logic                         pop,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic [7:0]                   out_byte,
	output logic                         out_group_last,
	output logic                         out_done,
	output logic                         out_bad
);

	logic [1:0] k_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;
	logic       bad_q;

	logic       emit;
	logic       last;
	logic [7:0] sel_byte;

	always_comb begin
		emit = (!valid_q || out_ready) && !q_status.empty;
		last = (k_q == head.cnt - 2'd1);
		unique case (k_q)
			2'd0:    sel_byte = head.word[23:16];
			2'd1:    sel_byte = head.word[15:8];
			default: sel_byte = head.word[7:0];
		endcase
		pop = emit && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				k_q     <= last ? 2'd0 : k_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= sel_byte;
			last_q <= last;
			done_q <= last && head.done;
			bad_q  <= head.bad;
		end
	end

	assign out_valid      = valid_q;
	assign out_byte       = byte_q;
	assign out_group_last = last_q;
	assign out_done       = done_q;
	assign out_bad        = bad_q;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the streaming base64 decoder: directed table, random messages, scoreboard.
`timescale 1ns / 1ps
module tb_top;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 96;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	// characters used to build requests
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TOP     = 8'hFF;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	base64_stream_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// one decoded byte or error marker as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       grp_last;
		logic       done;
		logic       bad;
	} dec_byte_t;

	// directed row; typed rows carry their own expectation
	typedef struct packed {
		logic [7:0]  ch;
		logic        eom;
		logic        typed;
		logic [1:0]  nbytes;
		logic [23:0] word;
		logic        err;
	} dir_row_t;

	localparam int DIR_N = 24;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// all-zero quad
		'{8'h41, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h41, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h41, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h41, 1'b0, 1'b1, 2'd3, 24'h000000, 1'b0},
		// all-ones quad
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h2F, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h2F, 1'b0, 1'b1, 2'd3, 24'hFFFFFF, 1'b0},
		// "TR==": double pad mid-stream, nonzero leftover bits dropped
		'{8'h54, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{8'h52, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{8'h3D, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{8'h3D, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		// NUL, pad in second slot, pad, 0xFF: invalid quad
		'{8'h00, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h3D, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h3D, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b1},
		// "AB=A" at message end: letter after a pad
		'{8'h41, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h42, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h3D, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h41, 1'b1, 1'b1, 2'd0, 24'h000000, 1'b1},
		// message ends on the third character
		'{8'h5A, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h39, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'h61, 1'b1, 1'b1, 2'd0, 24'h000000, 1'b1},
		// message ends on the first character
		'{8'h7A, 1'b1, 1'b1, 2'd0, 24'h000000, 1'b1}
	};

	// decoder state mirror
	logic [1:0]  pr_phase;
	logic [17:0] pr_acc;
	logic [1:0]  pr_pads;
	logic        pr_invalid;

	dec_byte_t quad_bytes[$];     // results of the latest character
	dec_byte_t byte_expect_q[$];  // results still owed by the block

	int src_idle_pct;
	int sink_stall_pct;
	int chars_sent;
	int bytes_checked;
	int errors_seen;
	int mismatches;
	int cycles;

	function automatic logic [6:0] sextet_value(input logic [7:0] c);
		if (c >= CH_UPPER_A && c < CH_UPPER_A + 8'd26) return 7'(c - CH_UPPER_A);
		if (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd26) return 7'(c - CH_LOWER_A + 8'd26);
		if (c >= CH_DIGIT_0 && c < CH_DIGIT_0 + 8'd10) return 7'(c - CH_DIGIT_0 + 8'd52);
		if (c == CH_PLUS) return 7'd62;
		if (c == CH_SLASH) return 7'd63;
		return 7'd64;
	endfunction

	function automatic logic [7:0] alphabet_char(input int idx);
		if (idx < 26) return CH_UPPER_A + 8'(idx);
		if (idx < 52) return CH_LOWER_A + 8'(idx - 26);
		if (idx < 62) return CH_DIGIT_0 + 8'(idx - 52);
		if (idx == 62) return CH_PLUS;
		return CH_SLASH;
	endfunction

	function automatic void clear_quad_state();
		pr_phase   = '0;
		pr_acc     = '0;
		pr_pads    = '0;
		pr_invalid = 1'b0;
	endfunction

	// Advance the mirror by one character, leaving its results in quad_bytes.
	function automatic void decode_char(input logic [7:0] c, input logic eom);
		logic [6:0]  v;
		logic [23:0] word;
		int          n;
		quad_bytes.delete();
		if (c == b64d_pkg::PAD_CHAR) begin
			v = '0;
			if (pr_phase < 2) begin
				pr_invalid = 1'b1;
			end else if (pr_pads < 2) begin
				pr_pads = pr_pads + 2'd1;
			end
		end else begin
			v = sextet_value(c);
			if (v[6]) begin
				pr_invalid = 1'b1;
				v = '0;
			end
			if (pr_pads != 0) pr_invalid = 1'b1;
		end
		if (pr_phase < 3) begin
			pr_acc   = {pr_acc[11:0], v[5:0]};
			pr_phase = pr_phase + 2'd1;
			// message ended inside the quad
			if (eom) begin
				quad_bytes.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
				clear_quad_state();
			end
			return;
		end
		if (pr_invalid) begin
			quad_bytes.push_back('{8'h00, 1'b1, eom, 1'b1});
		end else begin
			word = {pr_acc, v[5:0]};
			n = 3 - int'(pr_pads);
			for (int k = 0; k < n; k++) begin
				quad_bytes.push_back('{word[23 - 8 * k -: 8], k == n - 1, (k == n - 1) && eom,
					1'b0});
			end
		end
		clear_quad_state();
	endfunction

	// Offer one request, wait for its acceptance, then record what it owes.
	// Entered and left at a falling edge.
	task automatic send_char(input logic [7:0] c, input logic eom, input dir_row_t row);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
		decode_char(c, eom);
		if (row.typed) begin
			if (row.err) begin
				byte_expect_q.push_back('{8'h00, 1'b1, row.eom, 1'b1});
			end else begin
				for (int k = 0; k < int'(row.nbytes); k++) begin
					byte_expect_q.push_back('{row.word[23 - 8 * k -: 8],
						k == int'(row.nbytes) - 1, (k == int'(row.nbytes) - 1) && row.eom, 1'b0});
				end
			end
		end else begin
			foreach (quad_bytes[i]) byte_expect_q.push_back(quad_bytes[i]);
		end
		chars_sent++;
		@(negedge clk);
	endtask

	// Random messages: mostly well-formed quads, a few stray bytes and early ends.
	task automatic send_messages(input int target);
		dir_row_t   none;
		int         sent;
		int         nq;
		int         pads;
		logic [7:0] c;
		logic       eom;
		logic       broken;
		none   = '0;
		sent   = 0;
		while (sent < target) begin
			nq     = $urandom_range(4, 1);
			broken = 1'b0;
			for (int q = 0; q < nq && !broken && sent < target; q++) begin
				pads = 0;
				if (q == nq - 1 || $urandom_range(7) == 0) pads = $urandom_range(2);
				for (int pos = 0; pos < 4 && !broken && sent < target; pos++) begin
					c = (pos >= 4 - pads) ? b64d_pkg::PAD_CHAR :
						alphabet_char($urandom_range(63));
					if ($urandom_range(99) < 6) c = 8'($urandom_range(255));
					eom = (q == nq - 1) && (pos == 3);
					if ($urandom_range(99) < 3) begin
						eom    = 1'b1;
						broken = 1'b1;
					end
					send_char(c, eom, none);
					sent++;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// scoreboard: every taken result against the oldest one owed
	always @(posedge clk) begin
		dec_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (byte_expect_q.size() == 0) begin
				if (mismatches < MAX_REPORTS) begin
					$display("unexpected result: byte=%02h grp_last=%0b done=%0b bad=%0b",
						m_tdata[7:0], m_tdata[8], m_tlast, m_tuser[0]);
				end
				mismatches++;
			end else begin
				want = byte_expect_q.pop_front();
				if (m_tdata !== {7'b0, want.grp_last, want.data} || m_tlast !== want.done ||
					m_tuser[0] !== want.bad) begin
					if (mismatches < MAX_REPORTS) begin
						$display("result %0d: expected byte=%02h grp_last=%0b done=%0b bad=%0b",
							bytes_checked, want.data, want.grp_last, want.done, want.bad);
						$display("result %0d:   actual tdata=%04h done=%0b bad=%0b",
							bytes_checked, m_tdata, m_tlast, m_tuser[0]);
					end
					mismatches++;
				end
				if (want.bad) errors_seen++;
			end
			bytes_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				byte_expect_q.size());
			$display("[base64_stream_decoder] ERROR");
			$finish;
		end
	end

	initial begin
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		chars_sent     = 0;
		bytes_checked  = 0;
		errors_seen    = 0;
		mismatches     = 0;
		cycles         = 0;
		clear_quad_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		for (int i = 0; i < DIR_N; i++) begin
			send_char(DIR_ROWS[i].ch, DIR_ROWS[i].eom, DIR_ROWS[i]);
		end

		// random part across idling phases
		send_messages(RANDOM_ITEMS / 4);
		src_idle_pct   = 51;
		send_messages(RANDOM_ITEMS / 4);
		src_idle_pct   = 0;
		sink_stall_pct = 51;
		send_messages(RANDOM_ITEMS / 4);
		src_idle_pct   = 36;
		sink_stall_pct = 36;
		send_messages(RANDOM_ITEMS / 4);
		s_tvalid <= 1'b0;

		while (byte_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d characters over four idling phases; checked %0d results", chars_sent,
			bytes_checked);
		$display("of which %0d were error results; %0d mismatches", errors_seen, mismatches);
		if (mismatches == 0) begin
			$display("[base64_stream_decoder] OK");
		end else begin
			$display("[base64_stream_decoder] ERROR");
		end
		$finish;
	end

endmodule
